// ===== rtl/pam_pkg.sv =====
// ----------------------------------------------------------------------------
// pam_pkg
// Shared types and constants for the phase angle meter.
// ----------------------------------------------------------------------------
package pam_pkg;

   localparam int unsigned TICK_W = 32;

   // ticks between stamps that stand for zero degrees
   localparam logic [TICK_W-1:0] ZERO_DEG_TICKS = 32'd10000;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 32'd30000;

   localparam logic signed [15:0] ANGLE_MAX = 16'sd32767;

   // magnitudes at or above 2^MAG_W ticks always saturate the angle
   localparam int unsigned MAG_W = 18;
   // numerator 9*mag+25 fits in NUM_W bits
   localparam int unsigned NUM_W = 22;
   // floor(n/50) as (n*RECIP_MULT) >> RECIP_SHIFT, exact for n < 2^NUM_W
   localparam int unsigned RECIP_SHIFT = 28;
   localparam int unsigned RECIP_W     = 23;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 23'd5368710;
   localparam int unsigned QUOT_W = 17;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_AC   = 2'd1,
      STATUS_NO_LOAD = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_VOLT = 2'd1,
      PHASE_BOTH = 2'd2
   } phase_type;

   typedef struct packed {
      logic volt_level;
      logic current_level;
      logic poll;
   } req_payload_type;

   typedef struct packed {
      status_type        status;
      logic signed [15:0] angle_tenths;
      phase_type         phase;
   } rsp_payload_type;

endpackage

// ===== rtl/pam_angle.sv =====
// ----------------------------------------------------------------------------
// pam_angle
// Converts the tick difference between the two stamps into tenths of a degree.
// ----------------------------------------------------------------------------
module pam_angle (
   input  logic [pam_pkg::TICK_W-1:0] diff,
   output logic signed [15:0]         angle_tenths
);
   import pam_pkg::*;

   logic                           neg;
   logic [TICK_W-1:0]              mag_full;
   logic                           sat;
   logic [MAG_W-1:0]               mag;
   logic [NUM_W-1:0]               num;
   logic [RECIP_SHIFT+QUOT_W-1:0]  prod;
   logic [QUOT_W-1:0]              quot;

   assign neg      = (diff < ZERO_DEG_TICKS);
   assign mag_full = neg ? (ZERO_DEG_TICKS - diff) : (diff - ZERO_DEG_TICKS);
   assign sat      = !neg && (mag_full[TICK_W-1:MAG_W] != '0);
   assign mag      = mag_full[MAG_W-1:0];

   // round(18*mag/100) == floor((9*mag + 25) / 50)
   assign num  = ({{(NUM_W-MAG_W){1'b0}}, mag} << 3) + {{(NUM_W-MAG_W){1'b0}}, mag}
                 + NUM_W'(25);
   assign prod = (RECIP_SHIFT+QUOT_W)'(num) * (RECIP_SHIFT+QUOT_W)'(RECIP_MULT);
   assign quot = prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];

   always_comb begin
      if (neg) begin
         angle_tenths = -$signed({1'b0, quot[14:0]});
      end else if (sat || (quot > QUOT_W'(ANGLE_MAX))) begin
         angle_tenths = ANGLE_MAX;
      end else begin
         angle_tenths = $signed({1'b0, quot[14:0]});
      end
   end

endmodule

// ===== rtl/pam_core.sv =====
// ----------------------------------------------------------------------------
// pam_core
// Tick counter, edge stamps, poll evaluation and the timeout register.
// ----------------------------------------------------------------------------
module pam_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  pam_pkg::req_payload_type req,
   input  logic                     csr_write_enable,
   input  logic [31:0]              csr_write_data,
   output pam_pkg::rsp_payload_type result
);
   import pam_pkg::*;

   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [TICK_W-1:0]  timeout_ff;
   phase_type          phase_ff, phase_in;
   logic [TICK_W-1:0]  vt_ff, vt_in;
   logic [TICK_W-1:0]  ct_ff, ct_in;
   logic               prev_volt_ff, prev_cur_ff;
   status_type         status_ff, status_in;
   logic signed [15:0] angle_ff, angle_in;

   phase_type          phase_a, phase_b;
   logic [TICK_W-1:0]  vt_a, ct_b;
   logic [TICK_W-1:0]  elapsed;
   logic signed [15:0] angle_calc;

   pam_angle u_angle (
      .diff         (ct_b - vt_a),
      .angle_tenths (angle_calc)
   );

   assign elapsed = tick_ff - vt_a;
   assign tick_in = tick_ff + TICK_W'(1);

   always_comb begin
      // voltage edge first, then current edge, then the poll
      phase_a = phase_ff;
      vt_a    = vt_ff;
      if (req.volt_level && !prev_volt_ff && phase_ff == PHASE_IDLE) begin
         phase_a = PHASE_VOLT;
         vt_a    = tick_ff;
      end
      phase_b = phase_a;
      ct_b    = ct_ff;
      if (!req.current_level && prev_cur_ff && phase_a == PHASE_VOLT) begin
         phase_b = PHASE_BOTH;
         ct_b    = tick_ff;
      end

      phase_in  = phase_b;
      vt_in     = vt_a;
      ct_in     = ct_b;
      status_in = status_ff;
      angle_in  = angle_ff;
      if (req.poll) begin
         if (phase_b == PHASE_BOTH) begin
            status_in = STATUS_OK;
            if (ct_b > vt_a) begin
               angle_in = angle_calc;
            end
            phase_in = PHASE_IDLE;
            vt_in    = '0;
            ct_in    = '0;
         end else if (elapsed > timeout_ff) begin
            // a zero stamp counts as missing
            if (vt_a == '0) begin
               status_in = STATUS_NO_AC;
            end else if (ct_b == '0) begin
               status_in = STATUS_NO_LOAD;
            end
            phase_in = PHASE_IDLE;
            vt_in    = '0;
            ct_in    = '0;
         end
      end
   end

   assign result.status       = status_in;
   assign result.angle_tenths = angle_in;
   assign result.phase        = phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         phase_ff     <= PHASE_IDLE;
         vt_ff        <= '0;
         ct_ff        <= '0;
         prev_volt_ff <= 1'b1;
         prev_cur_ff  <= 1'b1;
         status_ff    <= STATUS_NO_AC;
         angle_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
         if (accept) begin
            tick_ff      <= tick_in;
            phase_ff     <= phase_in;
            vt_ff        <= vt_in;
            ct_ff        <= ct_in;
            prev_volt_ff <= req.volt_level;
            prev_cur_ff  <= req.current_level;
            status_ff    <= status_in;
            angle_ff     <= angle_in;
         end
      end
   end

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_IDLE |-> (vt_ff == '0 && ct_ff == '0))
      else $error("stamps left set while idle");

   a_volt_no_cur: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_VOLT |-> ct_ff == '0)
      else $error("current stamp set before voltage phase finished");

   a_angle_floor: assert property (@(posedge clock) disable iff (reset)
      angle_ff >= -16'sd1800)
      else $error("angle below lower bound");

endmodule

// ===== rtl/pam_skid.sv =====
// ----------------------------------------------------------------------------
// pam_skid
// Result register with one skid entry so a request can still be taken while the output is stalled.
// ----------------------------------------------------------------------------
module pam_skid (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  pam_pkg::rsp_payload_type in_data,
   output logic                     in_full,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output pam_pkg::rsp_payload_type rsp_data
);
   import pam_pkg::*;

   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   logic            skid_valid_ff;
   rsp_payload_type skid_data_ff;
   logic            out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_full   = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_valid;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_valid) begin
         skid_data_ff <= in_data;
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid filled while output was free");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !in_valid)
      else $error("write into full buffer");

endmodule

// ===== rtl/phase_angle_meter_unit.sv =====
// ----------------------------------------------------------------------------
// phase_angle_meter_unit
// Phase angle between voltage and current zero-cross square waves.
//
// Each request is one time tick carrying the two wave levels and a poll flag;
// every accepted request produces exactly one response with the status, the
// held angle in tenths of a degree and the measurement phase after that tick.
// Responses are registered. Throughput is one request per cycle while
// req_stall is low: the state update and angle math (one 22x23 multiply
// for the divide by 50) sit between the state registers and the result
// register. A one-entry skid behind the result register lets a request be
// taken while a response is stalled; req_stall rises only once the skid is
// occupied, and drops the cycle after the receiver takes a response.
// csr_write_enable loads the timeout in ticks; write it only while idle.
// Reset: tick counter and stamps cleared, timeout 30000, status no AC input,
// angle zero, response channel empty.
// ----------------------------------------------------------------------------
module phase_angle_meter_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pam_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output pam_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_write_enable,
   input  logic [31:0]              csr_write_data
);
   import pam_pkg::*;

   logic            accept;
   logic            full;
   rsp_payload_type result;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   pam_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req              (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .result           (result)
   );

   pam_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (result),
      .in_full   (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
